// File: rtl/power_alarm_monitor_defines.svh
// Assertion macros for the power alarm monitor RTL.
// No dependencies; included by the files that assert.
`ifndef POWER_ALARM_MONITOR_DEFINES_SVH
`define POWER_ALARM_MONITOR_DEFINES_SVH

// Explicit clock and active-low reset.
`define PAM_ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Default module clock and reset.
`define PAM_ASSERT(label, prop, msg) `PAM_ASSERT_RST(label, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/pam_pkg.sv
// Package for the power alarm monitor: widths, constants, register indexes, payload types.
// No dependencies.
`timescale 1ns / 1ps

package pam_pkg;

  localparam int unsigned SampleBits  = 20;
  localparam int unsigned LimitBits   = 2 * SampleBits;
  localparam int unsigned PctBits     = 8;
  localparam int unsigned MinuteBits  = 16;
  localparam int unsigned NowBits     = 32;
  localparam int unsigned DueBits     = NowBits + 1;
  localparam int unsigned ProdBits    = SampleBits + PctBits;
  localparam int unsigned CfgDataBits = LimitBits;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned NumLanes    = 3;
  localparam int unsigned AlertBits   = 3;

  localparam int unsigned ChangeFloor  = 100;
  localparam int unsigned PctScale     = 100;
  localparam int unsigned SecPerMinute = 60;
  localparam logic [PctBits-1:0] PctReset = 8'd15;

  localparam int unsigned AlertUnder  = 0;
  localparam int unsigned AlertOver   = 1;
  localparam int unsigned AlertChange = 2;

  localparam int unsigned LaneVoltage = 0;
  localparam int unsigned LaneCurrent = 1;
  localparam int unsigned LanePower   = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    RegVoltageLimits = 3'd0,
    RegCurrentLimits = 3'd1,
    RegPowerLimits   = 3'd2,
    RegVoltagePct    = 3'd3,
    RegCurrentPct    = 3'd4,
    RegPowerPct      = 3'd5,
    RegHeartbeatMin  = 3'd6
  } pam_reg_e;

  typedef logic [AlertBits-1:0] pam_alert_t;

  typedef struct packed {
    logic [SampleBits-1:0] voltage_sample;
    logic [SampleBits-1:0] current_sample;
    logic [SampleBits-1:0] power_sample;
    logic [NowBits-1:0]    now_seconds;
    logic                  time_valid;
  } pam_in_t;

  typedef struct packed {
    pam_alert_t voltage_alerts;
    pam_alert_t current_alerts;
    pam_alert_t power_alerts;
    logic       heartbeat_fired;
    logic       report_needed;
  } pam_out_t;

  // Findings of all lanes and the heartbeat for one transaction.
  typedef struct packed {
    pam_alert_t [NumLanes-1:0] alerts;
    logic                      hb;
  } pam_find_t;

endpackage

// File: rtl/pam_lane.sv
// One measurement lane: under, over and change checks plus previous/maximum tracking.
// Depends on pam_pkg.
`timescale 1ns / 1ps

module pam_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          first_i,
  input  logic [pam_pkg::SampleBits-1:0] sample_i,
  input  logic [pam_pkg::LimitBits-1:0]  limits_i,
  input  logic [pam_pkg::PctBits-1:0]    pct_i,
  output pam_pkg::pam_alert_t           alerts_o
);
  import pam_pkg::*;

  logic [SampleBits-1:0] prev_q, prev_d;
  logic [SampleBits-1:0] max_q, max_d;
  logic [SampleBits-1:0] prev_eff, max_eff;
  logic [SampleBits-1:0] under_lim, over_lim, diff;
  logic [ProdBits-1:0]   diff_scaled, max_scaled;

  always_comb begin
    prev_eff    = first_i ? sample_i : prev_q;
    max_eff     = first_i ? sample_i : max_q;
    under_lim   = limits_i[SampleBits-1:0];
    over_lim    = limits_i[LimitBits-1:SampleBits];
    diff        = (sample_i >= prev_eff) ? (sample_i - prev_eff) : (prev_eff - sample_i);
    diff_scaled = ProdBits'(diff) * ProdBits'(PctScale);
    max_scaled  = ProdBits'(max_eff) * ProdBits'(pct_i);

    alerts_o              = '0;
    alerts_o[AlertUnder]  = (under_lim != '0) && (sample_i < under_lim);
    alerts_o[AlertOver]   = (over_lim != '0) && (sample_i > over_lim);
    alerts_o[AlertChange] = (pct_i != '0) && (diff > SampleBits'(ChangeFloor))
                            && (diff_scaled > max_scaled);

    prev_d = prev_q;
    max_d  = max_q;
    if (accept_i) begin
      prev_d = sample_i;
      max_d  = (sample_i > max_eff) ? sample_i : max_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      max_q  <= '0;
    end else begin
      prev_q <= prev_d;
      max_q  <= max_d;
    end
  end

endmodule

// File: rtl/pam_heartbeat.sv
// Heartbeat scheduler: period tracking, due time and fire decision.
// Depends on pam_pkg.
`timescale 1ns / 1ps

module pam_heartbeat (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [pam_pkg::MinuteBits-1:0] minutes_i,
  input  logic                           time_valid_i,
  input  logic [pam_pkg::NowBits-1:0]    now_i,
  output logic                           fired_o
);
  import pam_pkg::*;

  logic [MinuteBits-1:0] period_q, period_d;
  logic [DueBits-1:0]    due_q, due_d;
  logic [DueBits-1:0]    due_eff, due_next;

  always_comb begin
    // a new period restarts the schedule
    due_eff  = (minutes_i != period_q) ? '0 : due_q;
    fired_o  = (minutes_i != '0) && time_valid_i && (DueBits'(now_i) > due_eff);
    due_next = DueBits'(now_i) + DueBits'(minutes_i) * DueBits'(SecPerMinute);

    period_d = period_q;
    due_d    = due_q;
    if (accept_i) begin
      period_d = minutes_i;
      due_d    = fired_o ? due_next : due_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      due_q    <= '0;
    end else begin
      period_q <= period_d;
      due_q    <= due_d;
    end
  end

endmodule

// File: rtl/pam_merge.sv
// Merge stage: combines lane and heartbeat findings into a result, output register plus skid.
// Depends on pam_pkg and power_alarm_monitor_defines.svh.
`timescale 1ns / 1ps
`include "power_alarm_monitor_defines.svh"

module pam_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pam_pkg::pam_find_t find_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pam_pkg::pam_out_t  out_data_o
);
  import pam_pkg::*;

  pam_out_t res;
  pam_out_t out_q, out_d, skid_q, skid_d;
  logic     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic     accept, pop;

  always_comb begin
    res.voltage_alerts  = find_i.alerts[LaneVoltage];
    res.current_alerts  = find_i.alerts[LaneCurrent];
    res.power_alerts    = find_i.alerts[LanePower];
    res.heartbeat_fired = find_i.hb;
    res.report_needed   = (|find_i.alerts) | find_i.hb;
  end

  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !out_ready_i) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = res;
        out_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `PAM_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with empty output")
  `PAM_ASSERT(a_stall_to_skid, (accept && out_valid_q && !out_ready_i) |=> skid_valid_q, "stalled transaction lost")
  `PAM_ASSERT(a_report_sum, out_valid_q |-> (out_q.report_needed == ((|out_q.voltage_alerts) || (|out_q.current_alerts) || (|out_q.power_alerts) || out_q.heartbeat_fired)), "report flag mismatch")

endmodule

// File: rtl/power_alarm_monitor.sv
// Power alarm monitor top level: configuration registers, three measurement lanes,
// heartbeat scheduler and merge stage. Depends on pam_pkg, pam_lane, pam_heartbeat, pam_merge.
`timescale 1ns / 1ps

// Every input transaction yields exactly one result transaction, registered in the output
// register, or in the skid while the output stalls; a new transaction is taken every cycle while
// the output side drains, and a two-entry output buffer lets one more be taken while a result
// waits. Per-cycle work is set by each lane's change check: two 20x8 multiplies and a compare.
// Configuration writes take effect at once and should be made while no transaction is in flight.
module power_alarm_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pam_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [pam_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pam_pkg::pam_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pam_pkg::pam_out_t               out_data_o
);
  import pam_pkg::*;

  logic [LimitBits-1:0]  lim_q [NumLanes];
  logic [PctBits-1:0]    pct_q [NumLanes];
  logic [MinuteBits-1:0] minutes_q;
  logic                  first_q;
  logic                  accept;
  logic [SampleBits-1:0] samples [NumLanes];
  pam_find_t             find;

  assign accept = in_valid_i && in_ready_o;
  assign samples[LaneVoltage] = in_data_i.voltage_sample;
  assign samples[LaneCurrent] = in_data_i.current_sample;
  assign samples[LanePower]   = in_data_i.power_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLanes; i++) begin
        lim_q[i] <= '0;
        pct_q[i] <= PctReset;
      end
      minutes_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegVoltageLimits: lim_q[LaneVoltage] <= cfg_data_i;
        RegCurrentLimits: lim_q[LaneCurrent] <= cfg_data_i;
        RegPowerLimits:   lim_q[LanePower]   <= cfg_data_i;
        RegVoltagePct:    pct_q[LaneVoltage] <= cfg_data_i[PctBits-1:0];
        RegCurrentPct:    pct_q[LaneCurrent] <= cfg_data_i[PctBits-1:0];
        RegPowerPct:      pct_q[LanePower]   <= cfg_data_i[PctBits-1:0];
        RegHeartbeatMin:  minutes_q          <= cfg_data_i[MinuteBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (accept) begin
      first_q <= 1'b0;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    pam_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .first_i  (first_q),
      .sample_i (samples[g]),
      .limits_i (lim_q[g]),
      .pct_i    (pct_q[g]),
      .alerts_o (find.alerts[g])
    );
  end

  pam_heartbeat u_heartbeat (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .minutes_i    (minutes_q),
    .time_valid_i (in_data_i.time_valid),
    .now_i        (in_data_i.now_seconds),
    .fired_o      (find.hb)
  );

  pam_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .find_i      (find),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
